@@ design/jmsp_pkg.sv @@
// Shared types, codes and helper functions for the JPEG marker segment parser.
// Used by the parser core, the result queue and the top level; depends on nothing.

package jmsp_pkg;

	// Marker bytes and framing limits.
	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] MK_SOI   = 8'hD8;
	localparam logic [7:0] MK_EOI   = 8'hD9;
	localparam logic [7:0] MK_SOS   = 8'hDA;
	localparam logic [7:0] MK_APP0  = 8'hE0;
	localparam logic [7:0] MK_APP1  = 8'hE1;
	localparam logic [7:0] MK_COM   = 8'hFE;
	localparam logic [2:0] MAX_FILL = 3'd6;
	localparam logic [7:0] COLOR_COMPONENTS = 8'd3;

	// Result kinds.
	localparam logic [1:0] KIND_SECTION = 2'd0;
	localparam logic [1:0] KIND_SCAN    = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_TOO_MANY  = 3'd2;
	localparam logic [2:0] ERR_FILL      = 3'd3;
	localparam logic [2:0] ERR_LENGTH    = 3'd4;
	localparam logic [2:0] ERR_TRUNC     = 3'd5;
	localparam logic [2:0] ERR_EOI       = 3'd6;

	// Configuration register indexes.
	localparam logic REG_READ_EXIF    = 1'b0;
	localparam logic REG_MAX_SECTIONS = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [7:0]  marker;
		logic [15:0] section_length;
		logic        is_frame;
		logic [15:0] frame_height;
		logic [15:0] frame_width;
		logic        is_color;
		logic        kept;
		logic [7:0]  kept_count;
		logic        last_of_run;
	} res_t;

	// Results produced by one accepted byte, handed to the result queue.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} push_t;

	function automatic res_t fail_res(input logic [2:0] code, input logic [7:0] count);
		res_t r;
		r = '0;
		r.kind = KIND_FAIL;
		r.error_code = code;
		r.kept_count = count;
		return r;
	endfunction

	function automatic logic is_frame_mk(input logic [7:0] m);
		return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
	endfunction

	// The four bytes of the Exif tag at the head of an APP1 payload.
	function automatic logic [7:0] exif_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h45;
			2'd1: b = 8'h78;
			2'd2: b = 8'h69;
			default: b = 8'h66;
		endcase
		return b;
	endfunction

endpackage

@@ design/jmsp_parse.sv @@
// Byte-wide framing state machine of the JPEG marker segment parser.
// Holds the parse state and emits up to two results per byte; uses jmsp_pkg.

module jmsp_parse import jmsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic        read_exif,
	input  logic [7:0]  max_sections,
	output push_t       push
);

	localparam logic [2:0] PH_START0 = 3'd0;
	localparam logic [2:0] PH_START1 = 3'd1;
	localparam logic [2:0] PH_MARK   = 3'd2;
	localparam logic [2:0] PH_LENHI  = 3'd3;
	localparam logic [2:0] PH_LENLO  = 3'd4;
	localparam logic [2:0] PH_BODY   = 3'd5;
	localparam logic [2:0] PH_STOP   = 3'd6;

	logic [2:0]  phase_q, fill_q;
	logic [7:0]  marker_q, comp_q, kept_q;
	logic [15:0] len_q, pidx_q, height_q, width_q;
	logic        exif_q, comment_q;

	// State as seen by this byte (reset to its start values when the byte opens a new file).
	logic [2:0]  e_phase, e_fill;
	logic [7:0]  e_marker, e_comp, e_kept;
	logic [15:0] e_len, e_pidx, e_height, e_width;
	logic        e_exif, e_comment;

	logic [2:0]  n_phase, n_fill;
	logic [7:0]  n_marker, n_comp, n_kept;
	logic [15:0] n_len, n_pidx, n_height, n_width;
	logic        n_exif, n_comment;

	logic [1:0]  cnt;
	res_t        r0, r1;

	always_comb begin
		e_phase   = first_byte ? PH_START0 : phase_q;
		e_fill    = first_byte ? 3'd0 : fill_q;
		e_marker  = first_byte ? 8'd0 : marker_q;
		e_comp    = first_byte ? 8'd0 : comp_q;
		e_kept    = first_byte ? 8'd0 : kept_q;
		e_len     = first_byte ? 16'd0 : len_q;
		e_pidx    = first_byte ? 16'd0 : pidx_q;
		e_height  = first_byte ? 16'd0 : height_q;
		e_width   = first_byte ? 16'd0 : width_q;
		e_exif    = first_byte ? 1'b1 : exif_q;
		e_comment = first_byte ? 1'b0 : comment_q;
	end

	always_comb begin
		logic       do_finish, do_bnd, chk_last, bnd_slot, keep, frame;
		logic [7:0] kcount;
		n_phase   = e_phase;
		n_fill    = e_fill;
		n_marker  = e_marker;
		n_comp    = e_comp;
		n_kept    = e_kept;
		n_len     = e_len;
		n_pidx    = e_pidx;
		n_height  = e_height;
		n_width   = e_width;
		n_exif    = e_exif;
		n_comment = e_comment;
		cnt       = 2'd0;
		r0        = '0;
		r1        = '0;
		do_finish = 1'b0;
		do_bnd    = 1'b0;
		chk_last  = 1'b0;
		bnd_slot  = 1'b0;
		keep      = 1'b0;
		frame     = 1'b0;
		kcount    = e_kept;

		case (e_phase)
			PH_START0: begin
				if (data_byte != BYTE_FF || last_byte) begin
					r0 = fail_res(ERR_BAD_START, e_kept);
					cnt = 2'd1;
					n_phase = PH_STOP;
				end else begin
					n_phase = PH_START1;
				end
			end
			PH_START1: begin
				if (data_byte != MK_SOI) begin
					r0 = fail_res(ERR_BAD_START, e_kept);
					cnt = 2'd1;
					n_phase = PH_STOP;
				end else begin
					do_bnd = 1'b1;
				end
			end
			PH_MARK: begin
				if (data_byte == BYTE_FF) begin
					if (e_fill >= MAX_FILL) begin
						r0 = fail_res(ERR_FILL, e_kept);
						cnt = 2'd1;
						n_phase = PH_STOP;
					end else begin
						n_fill = e_fill + 3'd1;
						chk_last = 1'b1;
					end
				end else begin
					n_marker = data_byte;
					n_height = 16'd0;
					n_width  = 16'd0;
					n_comp   = 8'd0;
					n_exif   = 1'b1;
					n_pidx   = 16'd0;
					n_phase  = PH_LENHI;
					chk_last = 1'b1;
				end
			end
			PH_LENHI: begin
				n_len = {data_byte, 8'h00};
				n_phase = PH_LENLO;
				chk_last = 1'b1;
			end
			PH_LENLO: begin
				n_len = {e_len[15:8], data_byte};
				if (n_len < 16'd2) begin
					r0 = fail_res(ERR_LENGTH, e_kept);
					cnt = 2'd1;
					n_phase = PH_STOP;
				end else if (n_len == 16'd2) begin
					do_finish = 1'b1;
				end else begin
					n_phase = PH_BODY;
					chk_last = 1'b1;
				end
			end
			PH_BODY: begin
				case (e_pidx)
					16'd1: n_height = {data_byte, 8'h00};
					16'd2: n_height = {e_height[15:8], data_byte};
					16'd3: n_width = {data_byte, 8'h00};
					16'd4: n_width = {e_width[15:8], data_byte};
					16'd5: n_comp = data_byte;
					default: ;
				endcase
				if (e_pidx < 16'd4 && data_byte != exif_byte(e_pidx[1:0])) begin
					n_exif = 1'b0;
				end
				n_pidx = e_pidx + 16'd1;
				if ({1'b0, e_pidx} + 17'd3 >= {1'b0, e_len}) begin
					do_finish = 1'b1;
				end else begin
					chk_last = 1'b1;
				end
			end
			default: ;
		endcase

		if (chk_last && last_byte) begin
			r0 = fail_res(ERR_TRUNC, e_kept);
			cnt = 2'd1;
			n_phase = PH_STOP;
		end

		if (do_finish) begin
			if (e_marker == MK_EOI) begin
				r0 = fail_res(ERR_EOI, e_kept);
				cnt = 2'd1;
				n_phase = PH_STOP;
			end else begin
				frame = is_frame_mk(e_marker);
				if (e_marker == MK_APP0) begin
					keep = 1'b0;
				end else if (e_marker == MK_COM) begin
					keep = read_exif && !e_comment;
					if (keep) begin
						n_comment = 1'b1;
					end
				end else if (e_marker == MK_APP1) begin
					keep = read_exif && n_exif && (n_len >= 16'd6);
				end else begin
					keep = 1'b1;
				end
				if (keep && e_kept != 8'hFF) begin
					kcount = e_kept + 8'd1;
				end
				n_kept = kcount;
				r0.kind = (e_marker == MK_SOS) ? KIND_SCAN : KIND_SECTION;
				r0.error_code = ERR_NONE;
				r0.marker = e_marker;
				r0.section_length = n_len;
				r0.is_frame = frame;
				r0.frame_height = frame ? n_height : 16'd0;
				r0.frame_width = frame ? n_width : 16'd0;
				r0.is_color = frame && (n_comp == COLOR_COMPONENTS);
				r0.kept = keep;
				r0.kept_count = kcount;
				cnt = 2'd1;
				if (e_marker == MK_SOS) begin
					n_phase = PH_STOP;
				end else begin
					do_bnd = 1'b1;
					bnd_slot = 1'b1;
				end
			end
		end

		// A section boundary checks the limit, then the end of the stream.
		if (do_bnd) begin
			if (kcount >= max_sections) begin
				if (bnd_slot) begin
					r1 = fail_res(ERR_TOO_MANY, kcount);
					cnt = 2'd2;
				end else begin
					r0 = fail_res(ERR_TOO_MANY, kcount);
					cnt = 2'd1;
				end
				n_phase = PH_STOP;
			end else begin
				n_phase = PH_MARK;
				n_fill = 3'd0;
				if (last_byte) begin
					if (bnd_slot) begin
						r1 = fail_res(ERR_TRUNC, kcount);
						cnt = 2'd2;
					end else begin
						r0 = fail_res(ERR_TRUNC, kcount);
						cnt = 2'd1;
					end
					n_phase = PH_STOP;
				end
			end
		end

		r0.last_of_run = (cnt == 2'd1);
		r1.last_of_run = (cnt == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START0;
			fill_q    <= 3'd0;
			marker_q  <= 8'd0;
			comp_q    <= 8'd0;
			kept_q    <= 8'd0;
			len_q     <= 16'd0;
			pidx_q    <= 16'd0;
			height_q  <= 16'd0;
			width_q   <= 16'd0;
			exif_q    <= 1'b1;
			comment_q <= 1'b0;
		end else if (take) begin
			phase_q   <= n_phase;
			fill_q    <= n_fill;
			marker_q  <= n_marker;
			comp_q    <= n_comp;
			kept_q    <= n_kept;
			len_q     <= n_len;
			pidx_q    <= n_pidx;
			height_q  <= n_height;
			width_q   <= n_width;
			exif_q    <= n_exif;
			comment_q <= n_comment;
		end
	end

	assign push.cnt  = take ? cnt : 2'd0;
	assign push.res0 = r0;
	assign push.res1 = r1;

`ifndef SYNTH
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && e_phase == PH_STOP) |-> (push.cnt == 2'd0))
		else $error("parser emitted a result after parsing had ended");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.res0.kind == KIND_SECTION && push.res1.kind == KIND_FAIL))
		else $error("second result on a byte must be a failure after a section");
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP && !(take && first_byte)) |=> (phase_q == PH_STOP))
		else $error("parser left the stopped phase without a new file");
`endif

endmodule

@@ design/jmsp_rq.sv @@
// Result queue of the JPEG marker segment parser: takes up to two results a
// cycle and hands them out one at a time. Uses the result types of jmsp_pkg.

module jmsp_rq import jmsp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output res_t  head,
	output logic  not_empty,
	output logic  room2
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q, wp1, wp2;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wp1 = ptr_inc(wptr_q);
	assign wp2 = ptr_inc(wp1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.cnt == 2'd1) begin
				wptr_q <= wp1;
			end else if (push.cnt == 2'd2) begin
				wptr_q <= wp2;
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	assign head      = mem_q[rptr_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CNT_W'(DEPTH - 2));

`ifndef SYNTH
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue holds more than its depth");
	a_fits: assert property (@(posedge clk) disable iff (!arst_n)
		((CNT_W + 1)'(count_q) + (CNT_W + 1)'(push.cnt) <= (CNT_W + 1)'(DEPTH)))
		else $error("results pushed into a full queue");
	a_track: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(!arst_n) |-> (count_q ==
		CNT_W'($past(count_q) + CNT_W'($past(push.cnt)) - CNT_W'($past(pop)))))
		else $error("queue fill level does not follow pushes and pops");
`endif

endmodule

@@ design/jpeg_marker_segment_parser_top.sv @@
// Top level of the JPEG marker segment parser: configuration registers,
// the framing state machine and the result queue. Uses jmsp_pkg, jmsp_parse, jmsp_rq.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-----------------------------------------
//  input    | in        | in_valid / in_stall    | data_byte, first_byte, last_byte
//  result   | out       | out_valid / out_stall  | kind, error_code, marker, ... last_of_run
//  config   | in        | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
//  One byte is taken per clock cycle while in_stall is low; a byte's results enter the
//  result queue at the edge that accepts it and may leave in the next cycle, one result
//  per cycle while out_stall is low. A byte that causes two results (a section plus a
//  boundary failure) needs two output transfers; the queue absorbs this, and in_stall
//  rises only when the queue cannot take two more results.
//  Reset clears the parse state, the queue and sets read_exif to 1 and max_sections to 20.
//  A stall on the result side fills the queue and then stalls the input side.

module jpeg_marker_segment_parser_top import jmsp_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Byte input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [2:0]  error_code,
	output logic [7:0]  marker,
	output logic [15:0] section_length,
	output logic        is_frame,
	output logic [15:0] frame_height,
	output logic [15:0] frame_width,
	output logic        is_color,
	output logic        kept,
	output logic [7:0]  kept_count,
	output logic        last_of_run,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        read_exif_q;
	logic [7:0]  max_sections_q;
	logic        take, pop, not_empty, room2;
	push_t       push;
	res_t        head;

	// Register writes complete in the access phase; the port never waits.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_exif_q    <= 1'b1;
			max_sections_q <= 8'd20;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_READ_EXIF:    read_exif_q <= pwdata[0];
				REG_MAX_SECTIONS: max_sections_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_READ_EXIF:    prdata = {31'd0, read_exif_q};
			REG_MAX_SECTIONS: prdata = {24'd0, max_sections_q};
			default:          prdata = 32'd0;
		endcase
	end

	// The input side is held off whenever the queue might not hold a byte's
	// worst case of two results; this depends only on the queue level.
	assign in_stall = !room2;
	assign take     = in_valid && !in_stall;

	jmsp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.read_exif    (read_exif_q),
		.max_sections (max_sections_q),
		.push         (push)
	);

	assign pop = not_empty && !out_stall;

	jmsp_rq #(
		.DEPTH (FIFO_DEPTH)
	) u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	// The head of the queue is the result transaction on offer.
	assign out_valid      = not_empty;
	assign kind           = head.kind;
	assign error_code     = head.error_code;
	assign marker         = head.marker;
	assign section_length = head.section_length;
	assign is_frame       = head.is_frame;
	assign frame_height   = head.frame_height;
	assign frame_width    = head.frame_width;
	assign is_color       = head.is_color;
	assign kept           = head.kept;
	assign kept_count     = head.kept_count;
	assign last_of_run    = head.last_of_run;

endmodule
